### rtl/core/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg
// Shared types and constants for the number literal scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package nls_pkg;

    typedef enum logic [3:0] {
        PH_START      = 4'd0,
        PH_SIGNED     = 4'd1,
        PH_ZERO       = 4'd2,
        PH_PREFIX     = 4'd3,
        PH_RADIX      = 4'd4,
        PH_WHOLE      = 4'd5,
        PH_BARE_DOT   = 4'd6,
        PH_POINT      = 4'd7,
        PH_FRACTION   = 4'd8,
        PH_EXP        = 4'd9,
        PH_EXP_SIGN   = 4'd10,
        PH_EXP_DIGITS = 4'd11,
        PH_DEAD       = 4'd15
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_INT   = 2'd1,
        KIND_FLOAT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    localparam int unsigned OUT_LEN_BITS = 16;

    // result transaction: kind in the low bits, length above
    typedef struct packed {
        logic [OUT_LEN_BITS-1:0] length;
        kind_t                   kind;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/number_literal_scanner.sv
// A scan's result is registered in the output register, or the skid entry while output waits.
// Throughput: one char per cycle if s_tready; the phase update is a single small transition.
// A two-entry output register (result plus skid) lets input carry on while a result waits.
// Reset (rst_n low, asynchronous): scan restarts at the start of a view, output queue empty.
// ----------------------------------------------------------------------------
// number_literal_scanner
// Finds the longest numeric literal prefix of each view, one character per
// transaction, and reports its kind and length once per view.
// ----------------------------------------------------------------------------
`default_nettype none

module number_literal_scanner #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_in[7:0]
    input  wire logic        s_tlast,   // view_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // literal_length[15:0]
    output logic [1:0]       m_tuser    // literal_kind[1:0]
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    nls_pkg::phase_t          phase_reg, phase_next, adv_phase;
    nls_pkg::kind_t           kind_reg, kind_next, adv_kind;
    nls_pkg::radix_t          radix_reg, radix_next, adv_radix;
    logic [LENGTH_BITS-1:0]   count_reg, count_next;
    logic [LENGTH_BITS-1:0]   acc_len_reg, acc_len_next;
    logic                     given_reg, given_next;

    nls_pkg::result_t         out_data_reg, skid_data_reg, new_result;
    logic                     out_valid_reg, out_valid_next;
    logic                     skid_valid_reg, skid_valid_next;

    logic                     accept, pop, push;
    logic                     is_dec, is_sign, is_exp, is_rdig;
    logic [7:0]               c;
    logic [31:0]              len_wide;

    assign c        = s_tdata;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.length;
    assign m_tuser  = out_data_reg.kind;
    assign pop      = out_valid_reg && m_tready;

    assign is_dec  = (c >= nls_pkg::CH_ZERO) && (c <= nls_pkg::CH_NINE);
    assign is_sign = (c == nls_pkg::CH_PLUS) || (c == nls_pkg::CH_MINUS);
    assign is_exp  = (c == nls_pkg::CH_LO_E) || (c == nls_pkg::CH_UP_E);

    always_comb
    begin
        case (radix_reg)
            nls_pkg::RADIX_BIN: is_rdig = (c == nls_pkg::CH_ZERO) || (c == nls_pkg::CH_ONE);
            nls_pkg::RADIX_OCT: is_rdig = (c >= nls_pkg::CH_ZERO) && (c <= nls_pkg::CH_SEVEN);
            nls_pkg::RADIX_HEX: is_rdig = is_dec
                                || ((c >= nls_pkg::CH_LO_A) && (c <= nls_pkg::CH_LO_F))
                                || ((c >= nls_pkg::CH_UP_A) && (c <= nls_pkg::CH_UP_F));
            default:            is_rdig = 1'b0;
        endcase
    end

    // phase transition for one character
    always_comb
    begin
        adv_phase = nls_pkg::PH_DEAD;
        adv_kind  = nls_pkg::KIND_NONE;
        adv_radix = radix_reg;
        case (phase_reg)
            nls_pkg::PH_START, nls_pkg::PH_SIGNED:
            begin
                if (is_sign && phase_reg == nls_pkg::PH_START) begin
                    adv_phase = nls_pkg::PH_SIGNED;
                end else if (c == nls_pkg::CH_ZERO) begin
                    adv_phase = nls_pkg::PH_ZERO;
                    adv_kind  = nls_pkg::KIND_INT;
                end else if (is_dec) begin
                    adv_phase = nls_pkg::PH_WHOLE;
                    adv_kind  = nls_pkg::KIND_INT;
                end else if (c == nls_pkg::CH_DOT) begin
                    adv_phase = nls_pkg::PH_BARE_DOT;
                end
            end
            nls_pkg::PH_ZERO, nls_pkg::PH_WHOLE:
            begin
                if (phase_reg == nls_pkg::PH_ZERO && c == nls_pkg::CH_LO_B) begin
                    adv_phase = nls_pkg::PH_PREFIX;
                    adv_radix = nls_pkg::RADIX_BIN;
                end else if (phase_reg == nls_pkg::PH_ZERO && c == nls_pkg::CH_LO_O) begin
                    adv_phase = nls_pkg::PH_PREFIX;
                    adv_radix = nls_pkg::RADIX_OCT;
                end else if (phase_reg == nls_pkg::PH_ZERO && c == nls_pkg::CH_LO_X) begin
                    adv_phase = nls_pkg::PH_PREFIX;
                    adv_radix = nls_pkg::RADIX_HEX;
                end else if (is_dec) begin
                    adv_phase = nls_pkg::PH_WHOLE;
                    adv_kind  = nls_pkg::KIND_INT;
                end else if (c == nls_pkg::CH_DOT) begin
                    adv_phase = nls_pkg::PH_POINT;
                    adv_kind  = nls_pkg::KIND_FLOAT;
                end else if (is_exp) begin
                    adv_phase = nls_pkg::PH_EXP;
                end
            end
            nls_pkg::PH_PREFIX, nls_pkg::PH_RADIX:
            begin
                if (is_rdig) begin
                    adv_phase = nls_pkg::PH_RADIX;
                    adv_kind  = nls_pkg::KIND_INT;
                end
            end
            nls_pkg::PH_BARE_DOT:
            begin
                if (is_dec) begin
                    adv_phase = nls_pkg::PH_FRACTION;
                    adv_kind  = nls_pkg::KIND_FLOAT;
                end
            end
            nls_pkg::PH_POINT, nls_pkg::PH_FRACTION:
            begin
                if (is_dec) begin
                    adv_phase = nls_pkg::PH_FRACTION;
                    adv_kind  = nls_pkg::KIND_FLOAT;
                end else if (is_exp) begin
                    adv_phase = nls_pkg::PH_EXP;
                end
            end
            nls_pkg::PH_EXP, nls_pkg::PH_EXP_SIGN, nls_pkg::PH_EXP_DIGITS:
            begin
                if (is_sign && phase_reg == nls_pkg::PH_EXP) begin
                    adv_phase = nls_pkg::PH_EXP_SIGN;
                end else if (is_dec) begin
                    adv_phase = nls_pkg::PH_EXP_DIGITS;
                    adv_kind  = nls_pkg::KIND_FLOAT;
                end
            end
            default:
            begin
                adv_phase = nls_pkg::PH_DEAD;
            end
        endcase
    end

    // scan state update and result formation
    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        radix_next   = radix_reg;
        count_next   = count_reg;
        acc_len_next = acc_len_reg;
        given_next   = given_reg;
        push         = 1'b0;
        if (accept && !given_reg) begin
            if (adv_phase != nls_pkg::PH_DEAD) begin
                phase_next = adv_phase;
                radix_next = adv_radix;
                if (count_reg != LEN_MAX) begin
                    count_next = count_reg + 1'b1;
                end
                if (adv_kind != nls_pkg::KIND_NONE) begin
                    acc_len_next = count_next;
                    kind_next    = adv_kind;
                end
            end
            push = (adv_phase == nls_pkg::PH_DEAD) || s_tlast;
        end
        len_wide = 32'(acc_len_next);
        new_result.kind = kind_next;
        if (kind_next == nls_pkg::KIND_NONE) begin
            new_result.length = '0;
        end else if (len_wide > 32'd65535) begin
            new_result.length = '1;
        end else begin
            new_result.length = len_wide[nls_pkg::OUT_LEN_BITS-1:0];
        end
        if (push) begin
            given_next = 1'b1;
        end
        // end of view restarts the scan whether or not a result went out
        if (accept && s_tlast) begin
            phase_next   = nls_pkg::PH_START;
            kind_next    = nls_pkg::KIND_NONE;
            radix_next   = nls_pkg::RADIX_DEC;
            count_next   = '0;
            acc_len_next = '0;
            given_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= nls_pkg::PH_START;
            kind_reg    <= nls_pkg::KIND_NONE;
            radix_reg   <= nls_pkg::RADIX_DEC;
            count_reg   <= '0;
            acc_len_reg <= '0;
            given_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            radix_reg   <= radix_next;
            count_reg   <= count_next;
            acc_len_reg <= acc_len_next;
            given_reg   <= given_next;
        end
    end

    // output register with a skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
            end else begin
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end else if (push && (pop || !out_valid_reg)) begin
            out_data_reg <= new_result;
        end
        if (push && out_valid_reg && !pop) begin
            skid_data_reg <= new_result;
        end
    end

endmodule

`default_nettype wire
